FILE: rtl/core/ebs_pkg.sv
// Shared package for the embedding bag sum block.
// Holds field widths, configuration register indexes and reset defaults.
// No dependencies.
package ebs_pkg;

  localparam int unsigned RowInW   = 10;  // row_index field
  localparam int unsigned ColInW   = 4;   // column_index and column fields
  localparam int unsigned WordW    = 32;  // Q16.16 table words and sums
  localparam int unsigned BagW     = 16;  // bag_number, bag_length, lookup count
  localparam int unsigned NColW    = 5;   // columns_in_use register
  localparam int unsigned RedKW    = 4;   // row reduction step counter
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned DefTableRows = 1024;
  localparam int unsigned DefMaxCols   = 16;
  localparam int unsigned OutColLimit  = 16;  // the column field reaches 15 at most

  localparam logic [CfgIdxW-1:0] CFG_BAG_LENGTH = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_COLUMNS    = 1'b1;

  localparam logic [BagW-1:0]  BAG_LENGTH_RST = 16'd1;
  localparam logic [NColW-1:0] COLUMNS_RST    = 5'd16;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

endpackage

FILE: rtl/core/ebs_table_mem.sv
// Embedding table storage: one write port, one read port, registered read data.
// Depends on ebs_pkg for the word width.
module ebs_table_mem import ebs_pkg::*; #(
  parameter int unsigned DEPTH  = DefTableRows * DefMaxCols,
  parameter int unsigned ADDR_W = 14
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WordW-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WordW-1:0]  rdata_o
);

  logic [WordW-1:0] mem_q [DEPTH];
  logic [WordW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/ebs_acc_mem.sv
// Bag accumulator storage with one valid bit per word; an invalid word reads zero.
// The whole accumulator clears at once through its valid bits. Depends on ebs_pkg.
module ebs_acc_mem import ebs_pkg::*; #(
  parameter int unsigned DEPTH  = DefMaxCols,
  parameter int unsigned ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clr_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WordW-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WordW-1:0]  rdata_o
);

  logic [WordW-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [WordW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= valid_q[raddr_i] ? mem_q[raddr_i] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clr_i) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/ebs_ctrl.sv
// Sequencer of the embedding bag sum: row reduction, table loads, the
// column-by-column read-add-write pass and result emission. Depends on ebs_pkg.
module ebs_ctrl import ebs_pkg::*; #(
  parameter int unsigned TABLE_ROWS  = DefTableRows,
  parameter int unsigned MAX_COLUMNS = DefMaxCols,
  parameter int unsigned ADDR_W      = 14,
  parameter int unsigned ACC_AW      = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_type_i,
  input  logic [RowInW-1:0] in_row_i,
  input  logic [ColInW-1:0] in_col_i,
  input  logic [WordW-1:0]  in_value_i,
  input  logic [NColW-1:0]  ncols_i,
  input  logic [BagW-1:0]   need_i,
  output logic              tab_we_o,
  output logic [ADDR_W-1:0] tab_waddr_o,
  output logic [WordW-1:0]  tab_wdata_o,
  output logic              tab_re_o,
  output logic [ADDR_W-1:0] tab_raddr_o,
  input  logic [WordW-1:0]  tab_rdata_i,
  output logic              acc_clr_o,
  output logic              acc_we_o,
  output logic [ACC_AW-1:0] acc_waddr_o,
  output logic [WordW-1:0]  acc_wdata_o,
  output logic              acc_re_o,
  output logic [ACC_AW-1:0] acc_raddr_o,
  input  logic [WordW-1:0]  acc_rdata_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [BagW-1:0]   out_bag_o,
  output logic [ColInW-1:0] out_col_o,
  output logic [WordW-1:0]  out_sum_o,
  output logic              out_last_o
);

  // Number of conditional subtractions that bring a row index into range.
  function automatic int red_steps(input int unsigned rows);
    int n;
    n = 0;
    for (int k = 0; k < RowInW; k++) begin
      if ((rows << k) < (1 << RowInW)) begin
        n++;
      end
    end
    return n;
  endfunction

  function automatic logic [WordW-1:0] sat_add(input logic [WordW-1:0] a,
                                               input logic [WordW-1:0] b);
    logic [WordW:0] s;
    s = {a[WordW-1], a} + {b[WordW-1], b};
    if (s[WordW] != s[WordW-1]) begin
      return s[WordW] ? {1'b1, {(WordW-1){1'b0}}} : {1'b0, {(WordW-1){1'b1}}};
    end
    return s[WordW-1:0];
  endfunction

  localparam int unsigned RedSteps = red_steps(TABLE_ROWS);
  localparam int unsigned RedK0    = (RedSteps > 0) ? RedSteps - 1 : 0;
  localparam logic [RowInW-1:0] RowsNarrow = RowInW'(TABLE_ROWS);
  localparam logic [ADDR_W-1:0] RowStride  = ADDR_W'(MAX_COLUMNS);
  localparam logic [6:0]        ColLimit   = 7'(MAX_COLUMNS);

  typedef enum logic [2:0] {
    ST_IDLE, ST_REDUCE, ST_LOAD, ST_LOOK, ST_EMIT_RD, ST_EMIT_WR
  } state_e;

  state_e             state_q;
  logic               look_q;
  logic [RowInW-1:0]  row_q;
  logic [ColInW-1:0]  col_q;
  logic [WordW-1:0]   value_q;
  logic               complete_q;
  logic [BagW-1:0]    cnt_q;
  logic [BagW-1:0]    bag_q;
  logic [RedKW-1:0]   red_k_q;
  logic [NColW-1:0]   c_q;
  logic               s1_q;
  logic [ACC_AW-1:0]  s1_col_q;
  logic               out_valid_q;
  logic [BagW-1:0]    out_bag_q;
  logic [ColInW-1:0]  out_col_q;
  logic [WordW-1:0]   out_sum_q;
  logic               out_last_q;

  logic [BagW-1:0]    cnt_next;
  logic               complete_now;
  logic [RowInW-1:0]  red_sub;
  logic [ADDR_W-1:0]  row_base;
  logic               issuing;
  logic               slot_free;
  logic               last_col;
  state_e             work_state;

  assign cnt_next     = cnt_q + BagW'(1);
  assign complete_now = (cnt_next >= need_i) || (cnt_next == '0);
  assign red_sub      = RowsNarrow << red_k_q;
  assign row_base     = ADDR_W'(row_q) * RowStride;
  assign issuing      = (c_q < ncols_i);
  assign slot_free    = !out_valid_q || out_ready_i;
  assign last_col     = (c_q + NColW'(1) == ncols_i);
  assign work_state   = look_q ? ST_LOOK : ST_LOAD;
  assign in_ready_o   = (state_q == ST_IDLE);

  always_comb begin
    tab_we_o    = 1'b0;
    tab_waddr_o = row_base + ADDR_W'(col_q);
    tab_wdata_o = value_q;
    tab_re_o    = 1'b0;
    tab_raddr_o = row_base + ADDR_W'(c_q);
    acc_re_o    = 1'b0;
    acc_raddr_o = ACC_AW'(c_q);
    acc_we_o    = s1_q;
    acc_waddr_o = s1_col_q;
    acc_wdata_o = sat_add(acc_rdata_i, tab_rdata_i);
    acc_clr_o   = 1'b0;
    unique case (state_q)
      ST_LOAD:    tab_we_o = ({3'b000, col_q} < ColLimit);
      ST_LOOK: begin
        tab_re_o = issuing;
        acc_re_o = issuing;
      end
      ST_EMIT_RD: acc_re_o = 1'b1;
      ST_EMIT_WR: acc_clr_o = slot_free && last_col;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      look_q      <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      value_q     <= '0;
      complete_q  <= 1'b0;
      cnt_q       <= '0;
      bag_q       <= '0;
      red_k_q     <= '0;
      c_q         <= '0;
      s1_q        <= 1'b0;
      s1_col_q    <= '0;
      out_valid_q <= 1'b0;
      out_bag_q   <= '0;
      out_col_q   <= '0;
      out_sum_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // The emit state refills the output register itself whenever the slot frees.
      if (out_valid_q && out_ready_i && (state_q != ST_EMIT_WR)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            look_q  <= (in_type_i == REQ_LOOKUP);
            row_q   <= in_row_i;
            col_q   <= in_col_i;
            value_q <= in_value_i;
            red_k_q <= RedKW'(RedK0);
            c_q     <= '0;
            if (in_type_i == REQ_LOOKUP) begin
              complete_q <= complete_now;
              cnt_q      <= complete_now ? '0 : cnt_next;
            end
            if (RedSteps > 0) begin
              state_q <= ST_REDUCE;
            end else begin
              state_q <= (in_type_i == REQ_LOOKUP) ? ST_LOOK : ST_LOAD;
            end
          end
        end
        ST_REDUCE: begin
          if (row_q >= red_sub) begin
            row_q <= row_q - red_sub;
          end
          if (red_k_q == '0) begin
            state_q <= work_state;
          end else begin
            red_k_q <= red_k_q - RedKW'(1);
          end
        end
        ST_LOAD: state_q <= ST_IDLE;
        ST_LOOK: begin
          s1_q     <= issuing;
          s1_col_q <= ACC_AW'(c_q);
          if (issuing) begin
            c_q <= c_q + NColW'(1);
          end else if (!s1_q) begin
            c_q     <= '0;
            state_q <= complete_q ? ST_EMIT_RD : ST_IDLE;
          end
        end
        ST_EMIT_RD: state_q <= ST_EMIT_WR;
        ST_EMIT_WR: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_bag_q   <= bag_q;
            out_col_q   <= ColInW'(c_q);
            out_sum_q   <= acc_rdata_i;
            out_last_q  <= last_col;
            if (last_col) begin
              bag_q   <= bag_q + BagW'(1);
              c_q     <= '0;
              state_q <= ST_IDLE;
            end else begin
              c_q     <= c_q + NColW'(1);
              state_q <= ST_EMIT_RD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_bag_o   = out_bag_q;
  assign out_col_o   = out_col_q;
  assign out_sum_o   = out_sum_q;
  assign out_last_o  = out_last_q;

endmodule

FILE: rtl/core/embedding_bag_sum.sv
// Embedding bag sum: a lookup reads one table word per cycle through the single table
// read port, and a lookup that completes a bag then emits its columns one at a time.
// A load writes one table word; with TABLE_ROWS below 1024 every item first passes
// through the row-folding steps. One item is in work at a time; finished words wait in an output register.
// Reset restores the registers to their defaults and clears the accumulator at once;
// the embedding table holds no defined contents until written.
module embedding_bag_sum import ebs_pkg::*; #(
  parameter int unsigned TABLE_ROWS  = DefTableRows,
  parameter int unsigned MAX_COLUMNS = DefMaxCols
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input stream: one word is a table load or a row lookup.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [47:0]         s_axis_tdata,   // row_index, column_index, word_value, zero pad
  input  logic                s_axis_tuser,   // req_type
  // Result stream: one word per summed column of a completed bag.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [55:0]         m_axis_tdata,   // bag_number, column, sum_value, zero pad
  output logic                m_axis_tlast,   // last_column
  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Sizes of the two memories. Rows are MAX_COLUMNS words apart in the table; only
  // the first sixteen columns can ever be summed, so the accumulator is no deeper.
  localparam int unsigned TabDepth = TABLE_ROWS * MAX_COLUMNS;
  localparam int unsigned TabAw    = (TabDepth > 1) ? $clog2(TabDepth) : 1;
  localparam int unsigned AccDepth = (MAX_COLUMNS < OutColLimit) ? MAX_COLUMNS : OutColLimit;
  localparam int unsigned AccAw    = (AccDepth > 1) ? $clog2(AccDepth) : 1;
  localparam logic [NColW-1:0] ColCap = NColW'(AccDepth);

  // Configuration registers.
  logic [BagW-1:0]  bag_length_q;
  logic [NColW-1:0] columns_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bag_length_q <= BAG_LENGTH_RST;
      columns_q    <= COLUMNS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BAG_LENGTH: bag_length_q <= cfg_data_i[BagW-1:0];
        CFG_COLUMNS:    columns_q    <= cfg_data_i[NColW-1:0];
        default: ;
      endcase
    end
  end

  // A bag length of zero behaves as one; the column count is clamped to [1, AccDepth].
  logic [BagW-1:0]  need;
  logic [NColW-1:0] ncols;

  assign need  = (bag_length_q == '0) ? BagW'(1) : bag_length_q;
  assign ncols = (columns_q == '0) ? NColW'(1) :
                 (columns_q > ColCap) ? ColCap : columns_q;

  logic              tab_we;
  logic [TabAw-1:0]  tab_waddr;
  logic [WordW-1:0]  tab_wdata;
  logic              tab_re;
  logic [TabAw-1:0]  tab_raddr;
  logic [WordW-1:0]  tab_rdata;
  logic              acc_clr;
  logic              acc_we;
  logic [AccAw-1:0]  acc_waddr;
  logic [WordW-1:0]  acc_wdata;
  logic              acc_re;
  logic [AccAw-1:0]  acc_raddr;
  logic [WordW-1:0]  acc_rdata;
  logic [BagW-1:0]   out_bag;
  logic [ColInW-1:0] out_col;
  logic [WordW-1:0]  out_sum;

  ebs_table_mem #(
    .DEPTH  (TabDepth),
    .ADDR_W (TabAw)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_waddr),
    .wdata_i (tab_wdata),
    .re_i    (tab_re),
    .raddr_i (tab_raddr),
    .rdata_o (tab_rdata)
  );

  ebs_acc_mem #(
    .DEPTH  (AccDepth),
    .ADDR_W (AccAw)
  ) u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (acc_clr),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .re_i    (acc_re),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  // The sequencer reads a table word and its accumulator word in the same cycle and
  // writes the saturated sum back in the next, so consecutive columns never
  // touch the same accumulator entry while a write is pending.
  ebs_ctrl #(
    .TABLE_ROWS  (TABLE_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS),
    .ADDR_W      (TabAw),
    .ACC_AW      (AccAw)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_type_i   (s_axis_tuser),
    .in_row_i    (s_axis_tdata[9:0]),
    .in_col_i    (s_axis_tdata[13:10]),
    .in_value_i  (s_axis_tdata[45:14]),
    .ncols_i     (ncols),
    .need_i      (need),
    .tab_we_o    (tab_we),
    .tab_waddr_o (tab_waddr),
    .tab_wdata_o (tab_wdata),
    .tab_re_o    (tab_re),
    .tab_raddr_o (tab_raddr),
    .tab_rdata_i (tab_rdata),
    .acc_clr_o   (acc_clr),
    .acc_we_o    (acc_we),
    .acc_waddr_o (acc_waddr),
    .acc_wdata_o (acc_wdata),
    .acc_re_o    (acc_re),
    .acc_raddr_o (acc_raddr),
    .acc_rdata_i (acc_rdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_bag_o   (out_bag),
    .out_col_o   (out_col),
    .out_sum_o   (out_sum),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, out_sum, out_col, out_bag};

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the embedding bag sum block.
// Drives table loads and row lookups, mirrors the bag sums and checks every result word.
// Depends on ebs_pkg and embedding_bag_sum.
`timescale 1ns / 1ps

module tb_top;
  import ebs_pkg::*;

  // The run is cut off here. The slowest correct run stays far below this.
  localparam int unsigned CycleLimit  = 600000;
  // After the last result, this many quiet cycles let the block finish any word
  // still in work, such as a load or a lookup that produces no result.
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned TableWords  = DefTableRows * DefMaxCols;
  localparam int unsigned Phases      = 8;
  localparam int unsigned PhaseItems  = 50;

  // One input word as the stimulus sees it.
  typedef struct packed {
    logic              kind;   // REQ_LOAD or REQ_LOOKUP
    logic [RowInW-1:0] row;
    logic [ColInW-1:0] col;
    logic [WordW-1:0]  value;
  } req_t;

  // One result word: a column sum of a finished bag.
  typedef struct packed {
    logic [BagW-1:0]   bag;
    logic [ColInW-1:0] col;
    logic [WordW-1:0]  sum;
    logic              last;
  } col_sum_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // All inputs of the block start at known values.
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [47:0]         s_axis_tdata  = '0;  // row_index, column_index, word_value, zero pad
  logic                s_axis_tuser  = 1'b0; // req_type
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [55:0]         m_axis_tdata;         // bag_number, column, sum_value, zero pad
  logic                m_axis_tlast;         // last_column
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  embedding_bag_sum DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Words waiting for the driver, and column sums waiting for the block.
  req_t     pending_words[$];
  col_sum_t sums_due[$];

  // Mirror of the block state, kept by the predictor.
  logic [WordW-1:0]  table_mirror [TableWords];
  logic [WordW-1:0]  acc_mirror   [DefMaxCols];
  logic [BagW-1:0]   lookup_count = '0;
  logic [BagW-1:0]   bag_count    = '0;
  logic [BagW-1:0]   bag_len_reg  = BAG_LENGTH_RST;
  logic [NColW-1:0]  columns_reg  = COLUMNS_RST;

  // Bookkeeping of the generator: which table words have been loaded so far, and
  // which rows are loaded in every column. A lookup never touches an unloaded word.
  bit                loaded    [TableWords];
  bit                row_full  [DefTableRows];
  int unsigned       full_rows[$];

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  bit          calm        = 1'b0;  // when set, neither side idles
  bit          word_taken  = 1'b0;  // input handshake at the last rising edge
  bit          sum_taken   = 1'b0;  // output handshake at the last rising edge

  initial begin
    for (int i = 0; i < DefMaxCols; i++) acc_mirror[i] = '0;
  end

  // Columns actually summed: zero acts as one, anything above the table width saturates.
  function automatic int unsigned active_columns();
    int unsigned n;
    n = columns_reg;
    if (n == 0) n = 1;
    if (n > OutColLimit) n = OutColLimit;
    if (n > DefMaxCols) n = DefMaxCols;
    return n;
  endfunction

  function automatic logic [WordW-1:0] sat_add(logic [WordW-1:0] a, logic [WordW-1:0] b);
    logic [WordW:0] s;
    s = {a[WordW-1], a} + {b[WordW-1], b};
    // The two top bits disagree only when the signed sum left the 32-bit range.
    if (s[WordW] != s[WordW-1]) return s[WordW] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return s[WordW-1:0];
  endfunction

  // Applies one accepted word to the mirror and queues the column sums it finishes.
  task automatic predict_bag(input req_t w);
    int unsigned ncols, need, base;
    col_sum_t    res;
    ncols = active_columns();
    need  = (bag_len_reg == 0) ? 1 : bag_len_reg;
    base  = (w.row % DefTableRows) * DefMaxCols;
    if (w.kind == REQ_LOAD) begin
      if (w.col < DefMaxCols) table_mirror[base + w.col] = w.value;
    end else begin
      for (int c = 0; c < ncols; c++) acc_mirror[c] = sat_add(acc_mirror[c], table_mirror[base + c]);
      lookup_count = lookup_count + 1'b1;
      // A bag closes once the count reaches the current length, even if the
      // length was lowered while the bag was half full.
      if (!(lookup_count < need && lookup_count != 0)) begin
        for (int c = 0; c < ncols; c++) begin
          res.bag  = bag_count;
          res.col  = c[ColInW-1:0];
          res.sum  = acc_mirror[c];
          res.last = (c + 1 == ncols);
          sums_due.push_back(res);
        end
        for (int c = 0; c < DefMaxCols; c++) acc_mirror[c] = '0;
        lookup_count = '0;
        bag_count    = bag_count + 1'b1;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    fail_count++;
  endtask

  // Monitor: outputs are compared first, then the word taken at this edge is predicted.
  // A result can never belong to the word accepted at the same edge.
  always @(posedge clk_i) begin : monitor
    col_sum_t got, want;
    req_t     w;
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      sum_taken  = rst_ni && m_axis_tvalid && m_axis_tready;
      word_taken = rst_ni && s_axis_tvalid && s_axis_tready;
      if (sum_taken) begin
        got.bag  = m_axis_tdata[15:0];
        got.col  = m_axis_tdata[19:16];
        got.sum  = m_axis_tdata[51:20];
        got.last = m_axis_tlast;
        if (sums_due.size() == 0) begin
          report_mismatch("result word with no sum pending, sum", got.sum, '0);
        end else begin
          want = sums_due.pop_front();
          if (got.bag !== want.bag)
            report_mismatch("bag_number", 32'(got.bag), 32'(want.bag));
          if (got.col !== want.col)
            report_mismatch("column", 32'(got.col), 32'(want.col));
          if (got.sum !== want.sum)
            report_mismatch("sum_value", got.sum, want.sum);
          if (got.last !== want.last)
            report_mismatch("last_column", 32'(got.last), 32'(want.last));
        end
      end
      if (word_taken) begin
        w.kind  = s_axis_tuser;
        w.row   = s_axis_tdata[9:0];
        w.col   = s_axis_tdata[13:10];
        w.value = s_axis_tdata[45:14];
        predict_bag(w);
      end
    end
  end

  // Source driver: presents queued words, with a random gap before each one.
  always @(negedge clk_i) begin : source_drive
    bit          in_flight;
    int unsigned gap;
    req_t        w;
    if (rst_ni) begin
      if (word_taken) in_flight = 1'b0;
      if (!in_flight) begin
        if (gap > 0) begin
          gap--;
        end else if (pending_words.size() > 0) begin
          w = pending_words.pop_front();
          s_axis_tdata <= {2'b00, w.value, w.col, w.row};
          s_axis_tuser <= w.kind;
          in_flight = 1'b1;
          gap = calm ? 0 : $urandom_range(0, 9);
        end
      end
      s_axis_tvalid <= in_flight;
    end
  end

  // Sink driver: after each result word it may hold tready low before taking the next.
  always @(negedge clk_i) begin : sink_drive
    int unsigned hold;
    if (rst_ni) begin
      if (m_axis_tready && sum_taken) hold = calm ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Draws table words: wide random, small Q16.16 magnitudes, the range limits or large values near them.
  function automatic logic [WordW-1:0] draw_word();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom())};
    endcase
  endfunction

  task automatic queue_load(input int unsigned row, input int unsigned col,
                            input logic [WordW-1:0] value);
    req_t w;
    bit   all;
    w.kind  = REQ_LOAD;
    w.row   = row[RowInW-1:0];
    w.col   = col[ColInW-1:0];
    w.value = value;
    pending_words.push_back(w);
    loaded[row * DefMaxCols + col] = 1'b1;
    all = 1'b1;
    for (int c = 0; c < DefMaxCols; c++) all &= loaded[row * DefMaxCols + c];
    if (all && !row_full[row]) begin
      row_full[row] = 1'b1;
      full_rows.push_back(row);
    end
  endtask

  // Lookups carry junk in the fields they do not use.
  task automatic queue_lookup(input int unsigned row);
    req_t w;
    w.kind  = REQ_LOOKUP;
    w.row   = row[RowInW-1:0];
    w.col   = ColInW'($urandom_range(0, 15));
    w.value = $urandom();
    pending_words.push_back(w);
  endtask

  function automatic bit row_ready(int unsigned row);
    for (int c = 0; c < active_columns(); c++)
      if (!loaded[row * DefMaxCols + c]) return 1'b0;
    return 1'b1;
  endfunction

  // Mostly well-formed traffic: whole-row loads followed by lookups of loaded rows,
  // with single stray loads mixed in.
  task automatic queue_random(input int unsigned count);
    int unsigned made, pick, row;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 12 || full_rows.size() == 0) begin
        row = $urandom_range(0, DefTableRows - 1);
        for (int c = 0; c < DefMaxCols; c++) queue_load(row, c, draw_word());
        made += DefMaxCols;
      end else if (pick < 35) begin
        row = $urandom_range(0, 1) ? full_rows[$urandom_range(0, full_rows.size() - 1)]
                                   : $urandom_range(0, DefTableRows - 1);
        queue_load(row, $urandom_range(0, DefMaxCols - 1), draw_word());
        made++;
      end else begin
        row = $urandom_range(0, DefTableRows - 1);
        if (!row_ready(row)) row = full_rows[$urandom_range(0, full_rows.size() - 1)];
        queue_lookup(row);
        made++;
      end
    end
  endtask

  // Waits until every queued word is taken and every sum has come back, then lets
  // the block finish any word that produces no result.
  task automatic settle();
    while (pending_words.size() != 0 || s_axis_tvalid || sums_due.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Register writes happen only while the block is idle, so the mirror can follow at once.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[CfgDataW-1:0];
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CFG_BAG_LENGTH) bag_len_reg = value[BagW-1:0];
    else columns_reg = value[NColW-1:0];
  endtask

  // Settings of the random phases. The 65535 bag never closes by itself, so the
  // next phase lowers the length while that bag is half full. Zero and values
  // above sixteen exercise the folding of the column count.
  int unsigned bag_plan [Phases] = '{1, 3, 65535, 2, 0, 5, 1, 4};
  int unsigned col_plan [Phases] = '{16, 4, 16, 31, 17, 8, 1, 0};

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset settings: one row at the range limits, summed as a
    // bag of one over all sixteen columns.
    for (int c = 0; c < DefMaxCols; c++)
      queue_load(DefTableRows - 1, c, (c % 2 == 0) ? 32'h7FFF_FFFF : 32'h8000_0000);
    queue_load(0, 0, 32'h0001_0000);
    queue_lookup(DefTableRows - 1);
    settle();

    // Two lookups of the limit row in one bag drive column zero into the positive
    // limit; then a plain bag of 1.0 + 1.0.
    write_reg(CFG_BAG_LENGTH, 2);
    write_reg(CFG_COLUMNS, 1);
    queue_lookup(DefTableRows - 1);
    queue_lookup(DefTableRows - 1);
    queue_lookup(0);
    queue_lookup(0);
    settle();

    // Zero in both registers acts as one.
    write_reg(CFG_BAG_LENGTH, 0);
    write_reg(CFG_COLUMNS, 0);
    queue_lookup(0);
    settle();

    for (int p = 0; p < Phases; p++) begin
      write_reg(CFG_BAG_LENGTH, bag_plan[p]);
      write_reg(CFG_COLUMNS, col_plan[p]);
      calm = (p % 3 == 2);
      queue_random(PhaseItems);
      settle();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
